// ===== rtl/run_queue_placement_macros.svh =====
// Assertion macros for the run queue placement checker.
`ifndef RUN_QUEUE_PLACEMENT_MACROS_SVH
`define RUN_QUEUE_PLACEMENT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define RQP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("run_queue_placement assertion failed");

// Next-cycle implication, sampled on clk, disabled in reset.
`define RQP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("run_queue_placement assertion failed");

`endif

// ===== rtl/rqp_pkg.sv =====
// Package: types and constants of the run queue placement block.
`timescale 1ns / 1ps

package rqp_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int COUNT_W    = 11;
    localparam int QUEUE_W    = 10;
    localparam int LANE_W     = 32;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int TDATA_W    = 16;

    localparam logic [LANE_W-1:0] HI_MULT      = 32'd36969;
    localparam logic [LANE_W-1:0] LO_MULT      = 32'd18000;
    localparam logic [LANE_W-1:0] DEFAULT_HI   = 32'd362436069;
    localparam logic [LANE_W-1:0] DEFAULT_LO   = 32'd521288629;
    localparam logic [LANE_W-1:0] LANE_MASK_LO = 32'd65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE    = 3'd0,
        REG_HUBS    = 3'd1,
        REG_COUNT   = 3'd2,
        REG_SEED_HI = 3'd3,
        REG_SEED_LO = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_PARENT    = 2'd0,
        MODE_RANDOM    = 2'd1,
        MODE_GLOBAL_RR = 2'd2,
        MODE_LOCAL_RR  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== rtl/rqp_ctrl.sv =====
// Controller state machine: accept, modulo sequencing and result hand-off.
`timescale 1ns / 1ps

module rqp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  rqp_pkg::ctrl_sts_t sts,
    output rqp_pkg::ctrl_cmd_t cmd
);
    import rqp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sts.need_div ? ST_LOAD : ST_FIN;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FIN:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/rqp_datapath.sv =====
// Datapath: configuration, generator lanes, round robin positions, divider, output register.
`timescale 1ns / 1ps

module rqp_datapath #(
    parameter int MAX_QUEUES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rqp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rqp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [rqp_pkg::QUEUE_W-1:0]         parent_queue,
    input  logic                                is_hub,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [rqp_pkg::QUEUE_W-1:0]         queue_index,
    output logic                                used_parent,
    input  rqp_pkg::ctrl_cmd_t                  cmd,
    output rqp_pkg::ctrl_sts_t                  sts
);
    import rqp_pkg::*;

    localparam logic [16:0] MAX_Q = 17'(MAX_QUEUES);

    // configuration
    mode_t                mode_reg;
    logic                 hubs_reg;
    logic [COUNT_W-1:0]   count_reg;

    // state
    logic [LANE_W-1:0]    hi_reg, hi_next;
    logic [LANE_W-1:0]    lo_reg, lo_next;
    logic [COUNT_W-1:0]   gpos_reg, gpos_next;
    logic [COUNT_W-1:0]   lpos_reg, lpos_next;

    // divider
    logic [LANE_W-1:0]    dividend_reg, dividend_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // pending result
    logic [QUEUE_W-1:0]   pick_reg, pick_next;
    logic                 parent_reg, parent_next;
    logic                 use_rem_reg, use_rem_next;

    // output stage
    logic                 out_valid_reg, out_valid_next;
    logic [QUEUE_W-1:0]   out_index_reg, out_index_next;
    logic                 out_parent_reg, out_parent_next;

    logic [COUNT_W-1:0]   n_eff;
    logic [16:0]          n_wide;
    logic                 policy;
    logic [COUNT_W-1:0]   gpos_use, lpos_use, gpos_adv, lpos_adv;
    logic [COUNT_W:0]     gpos_inc, lpos_inc;
    logic [LANE_W-1:0]    hi_step, lo_step;
    logic [COUNT_W:0]     rem_shift, rem_sub;

    always_comb
    begin
        n_wide = {6'd0, count_reg};
        if (n_wide == 17'd0)
        begin
            n_wide = 17'd1;
        end
        if (n_wide > MAX_Q)
        begin
            n_wide = MAX_Q;
        end
        n_eff = n_wide[COUNT_W-1:0];
    end

    assign policy = (mode_reg != MODE_PARENT) && (!hubs_reg || is_hub);

    assign gpos_use = (gpos_reg >= n_eff) ? '0 : gpos_reg;
    assign lpos_use = (lpos_reg >= n_eff) ? '0 : lpos_reg;
    assign gpos_inc = {1'b0, gpos_use} + 1'b1;
    assign lpos_inc = {1'b0, lpos_use} + 1'b1;
    assign gpos_adv = (gpos_inc >= {1'b0, n_eff}) ? '0 : gpos_inc[COUNT_W-1:0];
    assign lpos_adv = (lpos_inc >= {1'b0, n_eff}) ? '0 : lpos_inc[COUNT_W-1:0];

    assign hi_step = HI_MULT * (hi_reg & LANE_MASK_LO) + (hi_reg >> 16);
    assign lo_step = LO_MULT * (lo_reg & LANE_MASK_LO) + (lo_reg >> 16);

    assign rem_shift = {rem_reg, dividend_reg[LANE_W-1]};
    assign rem_sub   = rem_shift - {1'b0, n_eff};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PARENT;
            hubs_reg  <= 1'b0;
            count_reg <= COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:  mode_reg  <= mode_t'(cfg_wdata[1:0]);
                REG_HUBS:  hubs_reg  <= cfg_wdata[0];
                REG_COUNT: count_reg <= cfg_wdata[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        gpos_next    = gpos_reg;
        lpos_next    = lpos_reg;
        pick_next    = pick_reg;
        parent_next  = parent_reg;
        use_rem_next = use_rem_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_COUNT:
                begin
                    gpos_next = '0;
                    lpos_next = '0;
                end
                REG_SEED_HI:
                begin
                    hi_next = (cfg_wdata == '0) ? DEFAULT_HI : cfg_wdata;
                end
                REG_SEED_LO:
                begin
                    lo_next = (cfg_wdata == '0) ? DEFAULT_LO : cfg_wdata;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.accept)
        begin
            pick_next    = parent_queue;
            parent_next  = 1'b1;
            use_rem_next = 1'b0;
            if (policy)
            begin
                parent_next = 1'b0;
                case (mode_reg)
                    MODE_RANDOM:
                    begin
                        hi_next      = hi_step;
                        lo_next      = lo_step;
                        use_rem_next = 1'b1;
                    end
                    MODE_GLOBAL_RR:
                    begin
                        pick_next = gpos_use[QUEUE_W-1:0];
                        gpos_next = gpos_adv;
                    end
                    MODE_LOCAL_RR:
                    begin
                        pick_next = lpos_adv[QUEUE_W-1:0];
                        lpos_next = lpos_adv;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg      <= DEFAULT_HI;
            lo_reg      <= DEFAULT_LO;
            gpos_reg    <= '0;
            lpos_reg    <= '0;
            use_rem_reg <= 1'b0;
            parent_reg  <= 1'b1;
        end
        else
        begin
            hi_reg      <= hi_next;
            lo_reg      <= lo_next;
            gpos_reg    <= gpos_next;
            lpos_reg    <= lpos_next;
            use_rem_reg <= use_rem_next;
            parent_reg  <= parent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
    end

    // restoring modulo, one dividend bit per cycle
    always_comb
    begin
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        if (cmd.div_load)
        begin
            dividend_next = (hi_reg << 16) + lo_reg;
            rem_next      = '0;
            cnt_next      = '0;
        end
        else if (cmd.div_step)
        begin
            dividend_next = {dividend_reg[LANE_W-2:0], 1'b0};
            rem_next      = rem_sub[COUNT_W] ? rem_shift[COUNT_W-1:0] : rem_sub[COUNT_W-1:0];
            cnt_next      = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_index_next  = out_index_reg;
        out_parent_next = out_parent_reg;
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_index_next  = use_rem_reg ? rem_reg[QUEUE_W-1:0] : pick_reg;
            out_parent_next = parent_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg  <= out_index_next;
        out_parent_reg <= out_parent_next;
    end

    assign m_tvalid    = out_valid_reg;
    assign queue_index = out_index_reg;
    assign used_parent = out_parent_reg;

    assign sts.need_div = policy && (mode_reg == MODE_RANDOM);
    assign sts.div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.out_free = !out_valid_reg || m_tready;

endmodule

// ===== rtl/run_queue_placement.sv =====
// Top level of the run queue placement block.
`timescale 1ns / 1ps

// Picks a run queue for each new task transaction. Parent, fallback and both
// round robin policies pass from the accepting edge to the FIN state, which
// loads the result into the output register once that register is free. The
// random policy passes through LOAD (form the generator word), DIV (the
// bit-serial restoring modulo unit, paced by the divider's one bit per cycle)
// and FIN (hand-off to the output register), so no new input is taken until
// the divider has finished. One task is in flight at a time; the input is
// ready again once the result has moved to the output register, even while
// that result waits for m_tready.
module run_queue_placement #(
    parameter int MAX_QUEUES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rqp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rqp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rqp_pkg::TDATA_W-1:0]       s_tdata,   // [9:0] parent_queue, zero pad
    input  logic [0:0]                        s_tuser,   // [0] is_hub
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rqp_pkg::TDATA_W-1:0]       m_tdata,   // [9:0] queue_index, zero pad
    output logic [0:0]                        m_tuser    // [0] used_parent
);
    import rqp_pkg::*;

    ctrl_cmd_t          cmd;
    ctrl_sts_t          sts;
    logic [QUEUE_W-1:0] queue_index;
    logic               used_parent;

    rqp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rqp_datapath #(
        .MAX_QUEUES (MAX_QUEUES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .parent_queue (s_tdata[QUEUE_W-1:0]),
        .is_hub       (s_tuser[0]),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .queue_index  (queue_index),
        .used_parent  (used_parent),
        .cmd          (cmd),
        .sts          (sts)
    );

    assign m_tdata = {{(TDATA_W-QUEUE_W){1'b0}}, queue_index};
    assign m_tuser = used_parent;

endmodule

// ===== rtl/rqp_checker.sv =====
// Port-level checker for the run queue placement block, with its bind.
`timescale 1ns / 1ps
`include "run_queue_placement_macros.svh"

module rqp_checker (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready
);

    logic in_xact;

    assign in_xact = s_tvalid && s_tready;

    `RQP_ASSERT_NEXT(a_out_valid_holds, m_tvalid && !m_tready, m_tvalid)
    `RQP_ASSERT_NEXT(a_busy_after_accept, in_xact, !s_tready)
    `RQP_ASSERT_NEXT(a_no_early_result, in_xact, !$rose(m_tvalid))

endmodule

bind run_queue_placement rqp_checker u_rqp_checker (.*);

// ===== test/run_queue_placement_tb.sv =====
// Testbench for run_queue_placement: directed table, then random phases, all scoreboarded.
`timescale 1ns / 1ps

module run_queue_placement_tb;
    import rqp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd5;
    localparam int COUNT_CAP     = 1024;
    localparam int RANDOM_TASKS  = 750;
    localparam int SETTLE_CYCLES = 40;
    localparam int NUM_ROWS      = 40;

    typedef struct packed {
        logic [QUEUE_W-1:0] queue;
        logic               from_parent;
    } placement_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_TASK
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  wdata;
        logic [QUEUE_W-1:0]     parent;
        logic                   hub;
        logic                   typed;
        placement_t             want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [0:0]            m_tuser;

    run_queue_placement u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mirror of the block's registers and state
    mode_t              cfg_mode = MODE_PARENT;
    logic               cfg_hubs = 1'b0;
    logic [COUNT_W-1:0] cfg_count = 11'd1;
    logic [LANE_W-1:0]  lane_hi = DEFAULT_HI;
    logic [LANE_W-1:0]  lane_lo = DEFAULT_LO;
    logic [31:0]        global_pos = '0;
    logic [31:0]        local_pos = '0;

    placement_t pending_placements[$];
    int send_idle_pct = 29;
    int recv_idle_pct = 69;
    int mismatches = 0;
    int tasks_sent = 0;
    int results_seen = 0;
    int writes_done = 0;

    function automatic placement_t predict_placement(logic [QUEUE_W-1:0] parent, logic hub);
        logic [31:0] n;
        logic [31:0] word;
        placement_t  r;
        n = (cfg_count == 0) ? 32'd1 : (cfg_count > COUNT_CAP) ? 32'(COUNT_CAP) : 32'(cfg_count);
        r.queue = parent;
        r.from_parent = 1'b1;
        if (cfg_mode != MODE_PARENT && (!cfg_hubs || hub))
        begin
            r.from_parent = 1'b0;
            case (cfg_mode)
                MODE_RANDOM:
                begin
                    lane_hi = HI_MULT * (lane_hi & LANE_MASK_LO) + (lane_hi >> 16);
                    lane_lo = LO_MULT * (lane_lo & LANE_MASK_LO) + (lane_lo >> 16);
                    word = (lane_hi << 16) + lane_lo;
                    r.queue = QUEUE_W'(word % n);
                end
                MODE_GLOBAL_RR:
                begin
                    if (global_pos >= n)
                        global_pos = 0;
                    r.queue = QUEUE_W'(global_pos);
                    global_pos = (global_pos + 1 >= n) ? 0 : global_pos + 1;
                end
                default:
                begin
                    if (local_pos >= n)
                        local_pos = 0;
                    local_pos = (local_pos + 1 >= n) ? 0 : local_pos + 1;
                    r.queue = QUEUE_W'(local_pos);
                end
            endcase
        end
        return r;
    endfunction

    // Leaves cfg_we high; the next task transaction lowers it.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (reg_index_t'(idx))
            REG_MODE:    cfg_mode = mode_t'(data[1:0]);
            REG_HUBS:    cfg_hubs = data[0];
            REG_COUNT:
            begin
                cfg_count  = data[COUNT_W-1:0];
                global_pos = 0;
                local_pos  = 0;
            end
            REG_SEED_HI: lane_hi = (data != 0) ? data : DEFAULT_HI;
            REG_SEED_LO: lane_lo = (data != 0) ? data : DEFAULT_LO;
            default: ;
        endcase
        writes_done++;
        @(posedge clk);
    endtask

    task automatic send_task(logic [QUEUE_W-1:0] parent, logic hub, logic typed, placement_t want);
        placement_t got;
        cfg_we <= 1'b0;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(parent);
        s_tuser  <= hub;
        do @(posedge clk); while (!s_tready);
        got = predict_placement(parent, hub);
        pending_placements.push_back(typed ? want : got);
        tasks_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_placements.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_results
        placement_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_placements.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result queue_index=%0d used_parent=%0b",
                             $realtime, m_tdata[QUEUE_W-1:0], m_tuser[0]);
            end
            else
            begin
                want = pending_placements.pop_front();
                if (m_tdata[QUEUE_W-1:0] !== want.queue || m_tuser[0] !== want.from_parent)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch queue_index exp %0d got %0d, used_parent exp %0b got %0b",
                                 $realtime, want.queue, m_tdata[QUEUE_W-1:0],
                                 want.from_parent, m_tuser[0]);
                end
            end
        end
    end

    dir_row_t directed_rows [NUM_ROWS];

    initial
    begin
        int random_sent;
        int phase_len;
        int pick;
        logic [CFG_DATA_W-1:0] value;

        directed_rows = '{
            // mode parent after reset, field extremes
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd0,    1'b0, 1'b1, '{10'd0,    1'b1}},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd1023, 1'b1, 1'b1, '{10'd1023, 1'b1}},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd341,  1'b0, 1'b1, '{10'd341,  1'b1}},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd682,  1'b1, 1'b1, '{10'd682,  1'b1}},
            '{ROW_WRITE, REG_MODE, 32'(MODE_GLOBAL_RR), 10'd0, 1'b0, 1'b0, '0},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd1023, 1'b0, 1'b1, '{10'd0,    1'b0}},
            '{ROW_WRITE, REG_COUNT, 32'd3, 10'd0, 1'b0, 1'b0, '0},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd7,    1'b1, 1'b1, '{10'd0,    1'b0}},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd7,    1'b0, 1'b1, '{10'd1,    1'b0}},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd7,    1'b1, 1'b1, '{10'd2,    1'b0}},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd7,    1'b0, 1'b1, '{10'd0,    1'b0}},
            '{ROW_WRITE, REG_MODE, 32'(MODE_LOCAL_RR), 10'd0, 1'b0, 1'b0, '0},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd9,    1'b1, 1'b1, '{10'd1,    1'b0}},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd9,    1'b0, 1'b1, '{10'd2,    1'b0}},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd9,    1'b1, 1'b1, '{10'd0,    1'b0}},
            // hubs only: fallback keeps a parent above the count
            '{ROW_WRITE, REG_HUBS, 32'd1, 10'd0, 1'b0, 1'b0, '0},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd1023, 1'b0, 1'b1, '{10'd1023, 1'b1}},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd1,    1'b1, 1'b1, '{10'd1,    1'b0}},
            // count zero acts as one, oversize acts as the cap
            '{ROW_WRITE, REG_COUNT, 32'd0, 10'd0, 1'b0, 1'b0, '0},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd5,    1'b1, 1'b1, '{10'd0,    1'b0}},
            '{ROW_WRITE, REG_COUNT, 32'd2047, 10'd0, 1'b0, 1'b0, '0},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd5,    1'b1, 1'b1, '{10'd1,    1'b0}},
            '{ROW_WRITE, REG_MODE, 32'(MODE_GLOBAL_RR), 10'd0, 1'b0, 1'b0, '0},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd5,    1'b1, 1'b1, '{10'd0,    1'b0}},
            '{ROW_WRITE, REG_UNMAPPED, 32'hFFFF_FFFF, 10'd0, 1'b0, 1'b0, '0},
            '{ROW_WRITE, REG_HUBS, 32'd0, 10'd0, 1'b0, 1'b0, '0},
            // random mode, zero seeds load defaults; then all-ones seeds, oversize and unit counts
            '{ROW_WRITE, REG_MODE, 32'(MODE_RANDOM), 10'd0, 1'b0, 1'b0, '0},
            '{ROW_WRITE, REG_SEED_HI, 32'd0, 10'd0, 1'b0, 1'b0, '0},
            '{ROW_WRITE, REG_SEED_LO, 32'd0, 10'd0, 1'b0, 1'b0, '0},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd0,    1'b0, 1'b0, '0},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd1023, 1'b1, 1'b0, '0},
            '{ROW_WRITE, REG_SEED_HI, 32'hFFFF_FFFF, 10'd0, 1'b0, 1'b0, '0},
            '{ROW_WRITE, REG_SEED_LO, 32'hFFFF_FFFF, 10'd0, 1'b0, 1'b0, '0},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd100,  1'b0, 1'b0, '0},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd200,  1'b1, 1'b0, '0},
            '{ROW_WRITE, REG_COUNT, 32'd1025, 10'd0, 1'b0, 1'b0, '0},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd512,  1'b1, 1'b0, '0},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd511,  1'b0, 1'b0, '0},
            '{ROW_WRITE, REG_COUNT, 32'd1, 10'd0, 1'b0, 1'b0, '0},
            '{ROW_TASK,  REG_MODE, 32'd0, 10'd3,    1'b0, 1'b1, '{10'd0,    1'b0}}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                drain_results();
                write_register(directed_rows[i].index, directed_rows[i].wdata);
            end
            else
                send_task(directed_rows[i].parent, directed_rows[i].hub,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        random_sent = 0;
        while (random_sent < RANDOM_TASKS)
        begin
            drain_results();
            write_register(REG_MODE, 32'($urandom_range(3)));
            if ($urandom_range(1) == 0)
                write_register(REG_HUBS, 32'($urandom_range(3) == 0));
            if ($urandom_range(1) == 0)
            begin
                pick = $urandom_range(7);
                case (pick)
                    0: value = 32'd0;
                    1: value = 32'd1;
                    2: value = 32'd1024;
                    3: value = 32'd2047;
                    4: value = 32'($urandom_range(2047, 1025));
                    5: value = 32'($urandom_range(1024, 1));
                    default: value = 32'($urandom_range(16, 2));
                endcase
                write_register(REG_COUNT, value);
            end
            if ($urandom_range(3) == 0)
                write_register(REG_SEED_HI, ($urandom_range(3) == 0) ? 32'd0 : $urandom);
            if ($urandom_range(3) == 0)
                write_register(REG_SEED_LO, ($urandom_range(3) == 0) ? 32'd0 : $urandom);
            if ($urandom_range(7) == 0)
                write_register(CFG_IDX_W'($urandom_range(7, 5)), $urandom);

            phase_len = $urandom_range(50, 10);
            repeat (phase_len)
            begin
                if (random_sent < RANDOM_TASKS / 3)
                begin
                    send_idle_pct = 29;
                    recv_idle_pct = 69;
                end
                else if (random_sent < 2 * RANDOM_TASKS / 3)
                begin
                    send_idle_pct = 69;
                    recv_idle_pct = 29;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                send_task(QUEUE_W'($urandom_range(1023)), 1'($urandom_range(1)), 1'b0, '0);
                random_sent++;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_placements.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_placements.size());
            mismatches += pending_placements.size();
        end

        $display("Sent %0d task transactions (%0d directed rows), checked %0d results",
                 tasks_sent, NUM_ROWS, results_seen);
        $display("Register writes: %0d across all four modes and count extremes, %0d mismatches",
                 writes_done, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout waiting for the block");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
